### src/wsf_pkg.sv
`default_nettype none

package wsf_pkg;

  typedef logic [7:0] pixel_t;

  // input commands
  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int unsigned WIDTH_BITS  = 11;
  localparam int unsigned HEIGHT_BITS = 16;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;

  // ten 8-bit terms fit in 12 bits
  localparam int unsigned SUM_BITS = 12;

  // floor(x/10) = (x*52429) >> 19 for every 12-bit x
  localparam int unsigned  DIV10_BITS  = 16;
  localparam logic [15:0]  DIV10_MUL   = 16'd52429;
  localparam int unsigned  DIV10_SHIFT = 19;

  // result queue entries, covers the two pipeline stages in flight
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_CNT_BITS = 3;

endpackage

`default_nettype wire

### src/wsf_if.sv
`default_nettype none

interface wsf_in_if
  import wsf_pkg::*;
  ;
  logic   valid;
  logic   ready;
  logic   command;
  pixel_t pixel_in;

  modport source (output valid, output command, output pixel_in, input ready);
  modport sink   (input valid, input command, input pixel_in, output ready);
endinterface

interface wsf_out_if
  import wsf_pkg::*;
  ;
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

### src/wsf_ram.sv
`default_nettype none

module wsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/weighted_3x3_smoothing_filter.sv
`default_nettype none

// Weighted 3x3 smoothing filter for an 8-bit grayscale raster stream. A beat with
// command push carries one pixel; interior pixels come out as
// floor((8 neighbours + 2*centre)/10), border rows and columns pass unchanged.
// Results trail the input by width+1 accepted steps; after the frame is pushed,
// width+1 drain beats flush its tail, and the last pixel carries frame_end, which
// restarts the frame counters. Pushes beyond the frame and drains before it is
// complete are taken and ignored. The block takes one beat per clock while ready
// is high: the two line buffers are RAMs read at accept and written back in the
// next cycle, with forwarding when the same column is touched twice in a row
// (width one). A result passes stage 1 and 2 registers into the output queue;
// the queue keeps in_ch.ready high while the sink takes results. Writing either
// register restarts the frame; window and line buffers keep their contents.
module weighted_3x3_smoothing_filter
  import wsf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wsf_in_if.sink           in_ch,
  wsf_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = HEIGHT_BITS + 1;

  // configuration
  logic [WIDTH_BITS-1:0]  image_width_r;
  logic [HEIGHT_BITS-1:0] image_height_r;
  logic                   cfg_wr;
  logic [WW-1:0]          eff_w;
  logic [RW-1:0]          eff_h;

  // stream position
  logic [RW-1:0]          in_row_r,  in_row_nxt;
  logic [CW-1:0]          in_col_r,  in_col_nxt;
  logic [HEIGHT_BITS-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0]          out_col_r, out_col_nxt;

  logic in_fire, is_push, frame_full, active, emit, border, last;
  logic in_col_wrap, out_col_wrap;

  // stage 1: line buffer data back
  logic          s1_v_r, s1_push_r, s1_emit_r, s1_border_r, s1_last_r;
  pixel_t        s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  pixel_t        prev_rdata, prev2_rdata, prev_d, prev2_d, bot_d;
  logic          fwd_hit;
  logic          fwd_v_r;
  logic [CW-1:0] fwd_addr_r;
  pixel_t        fwd_prev_r, fwd_prev2_r;
  logic          lb_we;
  pixel_t        win_r [3][3];
  logic [SUM_BITS-1:0] sum_nxt;

  // stage 2: divide and select
  logic                s2_v_r, s2_border_r, s2_last_r;
  logic [SUM_BITS-1:0] s2_sum_r;
  pixel_t              s2_center_r;
  logic [SUM_BITS+DIV10_BITS-1:0] quot_full;
  pixel_t              s2_value;

  // result queue
  pixel_t                    q_pix_r [QUEUE_DEPTH];
  logic                      q_end_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] q_wr_r, q_rd_r;
  logic [QUEUE_CNT_BITS-1:0] q_cnt_r;
  logic                      q_push, q_pop;
  logic [QUEUE_CNT_BITS:0]   q_load;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width_r  <= pwdata[WIDTH_BITS-1:0];
        REG_HEIGHT: image_height_r <= pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {{(32-WIDTH_BITS){1'b0}}, image_width_r};
      REG_HEIGHT: prdata = {{(32-HEIGHT_BITS){1'b0}}, image_height_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
    eff_h = (image_height_r == '0) ? RW'(1) : {1'b0, image_height_r};
  end

  // ---------------------------------------------------------------- stage 0
  assign q_load      = {1'b0, q_cnt_r} + (QUEUE_CNT_BITS+1)'(s1_v_r)
                     + (QUEUE_CNT_BITS+1)'(s2_v_r);
  assign in_ch.ready = q_load <= (QUEUE_CNT_BITS+1)'(QUEUE_DEPTH - 1);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_push     = in_ch.command == CMD_PUSH;
  assign frame_full  = in_row_r >= eff_h;
  assign active      = in_fire && (is_push ? !frame_full : frame_full);

  // no result until the stream is width+1 steps in
  assign emit = !((in_row_r == '0) || ((in_row_r == RW'(1)) && (in_col_r == '0)));

  assign in_col_wrap  = (WW'(in_col_r) + WW'(1)) >= eff_w;
  assign out_col_wrap = (WW'(out_col_r) + WW'(1)) >= eff_w;
  assign last   = (({1'b0, out_row_r} + RW'(1)) >= eff_h) && out_col_wrap;
  assign border = (out_row_r == '0) || (({1'b0, out_row_r} + RW'(1)) >= eff_h)
               || (out_col_r == '0) || out_col_wrap;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (cfg_wr) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (active) begin
      if (in_col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end else if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HEIGHT_BITS'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      s1_v_r    <= active;
    end
  end

  always_ff @(posedge clk) begin
    s1_push_r   <= is_push;
    s1_pix_r    <= in_ch.pixel_in;
    s1_addr_r   <= in_col_r;
    s1_emit_r   <= emit;
    s1_border_r <= border;
    s1_last_r   <= last;
  end

  // ---------------------------------------------------------------- line buffers
  assign lb_we = s1_v_r && s1_push_r;

  wsf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .raddr (in_col_r),
    .rdata (prev_rdata)
  );

  wsf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_prev2 (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_addr_r),
    .wdata (prev_d),
    .raddr (in_col_r),
    .rdata (prev2_rdata)
  );

  // the write in the read's own cycle is not seen by the ram
  assign fwd_hit = fwd_v_r && (fwd_addr_r == s1_addr_r);
  assign prev_d  = fwd_hit ? fwd_prev_r  : prev_rdata;
  assign prev2_d = fwd_hit ? fwd_prev2_r : prev2_rdata;
  assign bot_d   = s1_push_r ? s1_pix_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= lb_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r  <= s1_addr_r;
    fwd_prev_r  <= s1_pix_r;
    fwd_prev2_r <= prev_d;
  end

  // ---------------------------------------------------------------- stage 1
  // window after the shift: old columns 1,2 plus the new column, centre twice
  assign sum_nxt = SUM_BITS'(win_r[0][1]) + SUM_BITS'(win_r[0][2]) + SUM_BITS'(prev2_d)
                 + SUM_BITS'(win_r[1][1]) + SUM_BITS'(win_r[1][2]) + SUM_BITS'(prev_d)
                 + SUM_BITS'(win_r[2][1]) + SUM_BITS'(win_r[2][2]) + SUM_BITS'(bot_d)
                 + SUM_BITS'(win_r[1][2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= prev2_d;
      win_r[1][2] <= prev_d;
      win_r[2][2] <= bot_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sum_r    <= sum_nxt;
    s2_center_r <= win_r[1][2];
    s2_border_r <= s1_border_r;
    s2_last_r   <= s1_last_r;
  end

  // ---------------------------------------------------------------- stage 2
  assign quot_full = (SUM_BITS+DIV10_BITS)'(s2_sum_r) * (SUM_BITS+DIV10_BITS)'(DIV10_MUL);
  assign s2_value  = s2_border_r ? s2_center_r : quot_full[DIV10_SHIFT +: 8];

  // ---------------------------------------------------------------- result queue
  assign q_push = s2_v_r;
  assign q_pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= q_wr_r + QUEUE_PTR_BITS'(1);
      end
      if (q_pop) begin
        q_rd_r <= q_rd_r + QUEUE_PTR_BITS'(1);
      end
      q_cnt_r <= q_cnt_r + QUEUE_CNT_BITS'(q_push) - QUEUE_CNT_BITS'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_pix_r[q_wr_r] <= s2_value;
      q_end_r[q_wr_r] <= s2_last_r;
    end
  end

  assign out_ch.valid     = q_cnt_r != '0;
  assign out_ch.pixel_out = q_pix_r[q_rd_r];
  assign out_ch.frame_end = q_end_r[q_rd_r];

endmodule

`default_nettype wire
